// ===== rtl/lcfp_pkg.sv =====
// shared constants, codes and decode functions for the led command frame parser
// no dependencies; used by lcfp_frame and led_command_frame_parser
`default_nettype none

package lcfp_pkg;

	// frame geometry
	localparam int unsigned FrameLen  = 19;
	localparam int unsigned PosW      = 5;
	localparam logic [PosW-1:0] PosSat   = 5'd20;
	localparam logic [PosW-1:0] PosClose = 5'(FrameLen - 1);
	localparam int unsigned NumFields = 7;

	// characters
	localparam logic [7:0] CharOpen  = 8'd91;   // '['
	localparam logic [7:0] CharClose = 8'd93;   // ']'
	localparam logic [7:0] CharDig0  = 8'd48;
	localparam logic [7:0] CharDig9  = 8'd57;
	localparam logic [7:0] CharUpA   = 8'd65;
	localparam logic [7:0] CharUpF   = 8'd70;
	localparam logic [7:0] CharLoA   = 8'd97;
	localparam logic [7:0] CharLoF   = 8'd102;

	// field codes
	localparam logic [2:0] FieldMode   = 3'd0;
	localparam logic [2:0] FieldWhite  = 3'd1;
	localparam logic [2:0] FieldRed    = 3'd2;
	localparam logic [2:0] FieldGreen  = 3'd3;
	localparam logic [2:0] FieldBlue   = 3'd4;
	localparam logic [2:0] FieldBright = 3'd5;
	localparam logic [2:0] FieldSpeed  = 3'd6;
	localparam logic [2:0] FieldNone   = 3'd7;

	// held settings after reset
	localparam logic [7:0]  RstMode   = 8'd3;
	localparam logic [7:0]  RstWhite  = 8'd0;
	localparam logic [7:0]  RstRed    = 8'd0;
	localparam logic [7:0]  RstGreen  = 8'd255;
	localparam logic [7:0]  RstBlue   = 8'd0;
	localparam logic [7:0]  RstBright = 8'd92;
	localparam logic [15:0] RstSpeed  = 16'd196;
	localparam logic [15:0] ErrGrowth = 16'd100;

	// frame state seen by the top level
	typedef struct packed {
		logic [PosW-1:0]           pos;
		logic                      opened;
		logic                      closed;
		logic [NumFields-1:0][7:0] acc;
	} frame_st_t;

	// hex digit value; other bytes map as their own value, zero or fifteen
	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		logic [7:0] v;
		begin
			if (c inside {[CharDig0:CharDig9]}) begin
				v = c - CharDig0;
			end else if (c inside {[CharUpA:CharUpF]}) begin
				v = c - CharUpA + 8'd10;
			end else if (c inside {[CharLoA:CharLoF]}) begin
				v = c - CharLoA + 8'd10;
			end else if (c[7]) begin
				v = 8'd0;
			end else if (c < 8'd16) begin
				v = c;
			end else begin
				v = 8'd15;
			end
			nibble_of = v[3:0];
		end
	endfunction

	// field fed at each frame position
	function automatic logic [2:0] field_at(input logic [PosW-1:0] pos);
		logic [2:0] f;
		begin
			case (pos)
				5'd1, 5'd2:   f = FieldMode;
				5'd4, 5'd5:   f = FieldWhite;
				5'd6, 5'd7:   f = FieldRed;
				5'd8, 5'd9:   f = FieldGreen;
				5'd10, 5'd11: f = FieldBlue;
				5'd13, 5'd14: f = FieldBright;
				5'd16, 5'd17: f = FieldSpeed;
				default:      f = FieldNone;
			endcase
			field_at = f;
		end
	endfunction

endpackage

`default_nettype wire

// ===== rtl/lcfp_frame.sv =====
// per-frame state: byte position, bracket flags and the seven hex accumulators
// depends on lcfp_pkg
`default_nettype none

module lcfp_frame (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire logic [7:0]         rx_byte,
	input  wire logic               is_last,
	output lcfp_pkg::frame_st_t     st
);

	lcfp_pkg::frame_st_t st_q;
	logic [2:0]          fld;
	logic [3:0]          nib;
	logic                feed;

	assign fld  = lcfp_pkg::field_at(st_q.pos);
	assign nib  = lcfp_pkg::nibble_of(rx_byte);
	assign feed = !st_q.closed && (rx_byte != lcfp_pkg::CharClose)
		&& (fld != lcfp_pkg::FieldNone);
	assign st   = st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (step) begin
			if (is_last) begin
				// end of frame: back to the empty frame
				st_q <= '0;
			end else begin
				if (st_q.pos != lcfp_pkg::PosSat) begin
					st_q.pos <= st_q.pos + 5'd1;
				end
				if (st_q.pos == '0 && rx_byte == lcfp_pkg::CharOpen) begin
					st_q.opened <= 1'b1;
				end
				if (rx_byte == lcfp_pkg::CharClose) begin
					st_q.closed <= 1'b1;
				end
				if (feed) begin
					st_q.acc[fld] <= {st_q.acc[fld][3:0], nib};
				end
			end
		end
	end

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.pos <= lcfp_pkg::PosSat)
		else $error("frame position beyond saturation");

	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && is_last |=> st_q == '0)
		else $error("frame state not cleared after last byte");

	a_closed_stays: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.closed && step && !is_last |=> st_q.closed)
		else $error("close flag dropped inside a frame");

endmodule

`default_nettype wire

// ===== rtl/led_command_frame_parser.sv =====
// led command frame parser: input register, frame state, held settings, result register
// output: a frame's last byte passes the input register, then m_tvalid rises with its registered result
// throughput: one byte per cycle; s_tready drops only while a frame end waits on a full result register
// reset: arst_n clears the frame state and loads mode 3, green 255, brightness 92, speed 196
// depends on lcfp_pkg and lcfp_frame
`default_nettype none

module led_command_frame_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  wire logic        s_tlast,   // is_last
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata    // [0] frame_ok, [8:1] mode_out, [16:9] white_out,
	                                    // [24:17] red_out, [32:25] green_out, [40:33] blue_out,
	                                    // [48:41] brightness_out, [64:49] speed_out, rest zero
);

	// input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// advance: non-final bytes always move on; a frame end needs room for its result
	logic adv;
	logic take;
	assign adv      = valid_s1 && (!last_s1 || !m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// frame tracking
	lcfp_pkg::frame_st_t st;

	lcfp_frame u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.rx_byte (byte_s1),
		.is_last (last_s1),
		.st      (st)
	);

	// frame check on its last byte
	logic       fire;
	logic       opened;
	logic       ok;
	logic [7:0] sp;
	assign fire   = adv && last_s1;
	assign opened = st.opened || (st.pos == '0 && byte_s1 == lcfp_pkg::CharOpen);
	assign ok     = opened && byte_s1 == lcfp_pkg::CharClose && st.pos == lcfp_pkg::PosClose;
	assign sp     = st.acc[lcfp_pkg::FieldSpeed];

	// held settings
	logic [7:0]  mode_q, white_q, red_q, green_q, blue_q, bright_q;
	logic [15:0] speed_q;
	logic [15:0] speed_next;

	always_comb begin
		if (ok) begin
			// accepted speed is clamped to 1..255
			speed_next = (sp == 8'd0) ? 16'd1 : {8'd0, sp};
		end else begin
			// reject: delay grows, wrapping at 16 bits
			speed_next = speed_q + lcfp_pkg::ErrGrowth;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= lcfp_pkg::RstMode;
			white_q  <= lcfp_pkg::RstWhite;
			red_q    <= lcfp_pkg::RstRed;
			green_q  <= lcfp_pkg::RstGreen;
			blue_q   <= lcfp_pkg::RstBlue;
			bright_q <= lcfp_pkg::RstBright;
			speed_q  <= lcfp_pkg::RstSpeed;
		end else if (fire) begin
			speed_q <= speed_next;
			if (ok) begin
				mode_q   <= st.acc[lcfp_pkg::FieldMode];
				white_q  <= st.acc[lcfp_pkg::FieldWhite];
				red_q    <= st.acc[lcfp_pkg::FieldRed];
				green_q  <= st.acc[lcfp_pkg::FieldGreen];
				blue_q   <= st.acc[lcfp_pkg::FieldBlue];
				bright_q <= st.acc[lcfp_pkg::FieldBright];
			end
		end
	end

	// result register
	logic        out_valid_q;
	logic [64:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (ok) begin
				out_data_q <= {speed_next, st.acc[lcfp_pkg::FieldBright],
					st.acc[lcfp_pkg::FieldBlue], st.acc[lcfp_pkg::FieldGreen],
					st.acc[lcfp_pkg::FieldRed], st.acc[lcfp_pkg::FieldWhite],
					st.acc[lcfp_pkg::FieldMode], 1'b1};
			end else begin
				out_data_q <= {speed_next, bright_q, blue_q, green_q, red_q, white_q,
					mode_q, 1'b0};
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_data_q};

	// an accepted frame always shows a speed in 1..255
	a_ok_speed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[64:57] == 8'd0 && m_tdata[56:49] != 8'd0)
		else $error("accepted frame with speed out of range");

	// input stalls only behind a frame end blocked by a full result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && last_s1 && m_tvalid && !m_tready)
		else $error("input stalled without cause");

	// a reject adds the growth step to the held speed
	a_reject_growth: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !ok |=> speed_q == 16'($past(speed_q) + lcfp_pkg::ErrGrowth))
		else $error("reject did not grow speed");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench for led_command_frame_parser: byte stream in, settings result out
// keeps its own frame parser model in a scoreboard class and compares every result transfer
// depends on lcfp_pkg and the led_command_frame_parser rtl
`default_nettype none

module testbench;

	localparam logic [7:0] CharSep = 8'd58;   // ':'

	// result word as it sits on m_tdata, lowest bit last
	typedef struct packed {
		logic [6:0]  pad;
		logic [15:0] speed;
		logic [7:0]  bright;
		logic [7:0]  blue, green, red, white, mode;
		logic        ok;
	} frame_result_t;

	// model of the parser plus the queue of settings words still to come out
	class frame_scoreboard;
		logic [lcfp_pkg::PosW-1:0] pos;
		bit              opened;
		bit              closed;
		logic [7:0]      acc [0:lcfp_pkg::NumFields-1];
		logic [7:0]      mode, white, red, green, blue, bright;
		logic [15:0]     speed;
		frame_result_t   expected [$];
		int              mismatches;

		function new();
			clear_frame();
			mode   = lcfp_pkg::RstMode;
			white  = lcfp_pkg::RstWhite;
			red    = lcfp_pkg::RstRed;
			green  = lcfp_pkg::RstGreen;
			blue   = lcfp_pkg::RstBlue;
			bright = lcfp_pkg::RstBright;
			speed  = lcfp_pkg::RstSpeed;
			mismatches = 0;
		endfunction

		function void clear_frame();
			pos    = '0;
			opened = 0;
			closed = 0;
			for (int i = 0; i < lcfp_pkg::NumFields; i++) acc[i] = 8'd0;
		endfunction

		// value of one character as a hex digit, with the fallbacks for other bytes
		function logic [3:0] hex_value(logic [7:0] c);
			if (c >= lcfp_pkg::CharDig0 && c <= lcfp_pkg::CharDig9)
				return 4'(c - lcfp_pkg::CharDig0);
			if (c >= lcfp_pkg::CharUpA && c <= lcfp_pkg::CharUpF)
				return 4'(c - lcfp_pkg::CharUpA + 8'd10);
			if (c >= lcfp_pkg::CharLoA && c <= lcfp_pkg::CharLoF)
				return 4'(c - lcfp_pkg::CharLoA + 8'd10);
			if (c >= 8'd128) return 4'd0;
			if (c < 8'd16) return c[3:0];
			return 4'd15;
		endfunction

		function logic [2:0] field_code(logic [lcfp_pkg::PosW-1:0] p);
			case (p)
				5'd1, 5'd2:   return lcfp_pkg::FieldMode;
				5'd4, 5'd5:   return lcfp_pkg::FieldWhite;
				5'd6, 5'd7:   return lcfp_pkg::FieldRed;
				5'd8, 5'd9:   return lcfp_pkg::FieldGreen;
				5'd10, 5'd11: return lcfp_pkg::FieldBlue;
				5'd13, 5'd14: return lcfp_pkg::FieldBright;
				5'd16, 5'd17: return lcfp_pkg::FieldSpeed;
				default:      return lcfp_pkg::FieldNone;
			endcase
		endfunction

		// one accepted byte; a frame end queues the settings word it produces
		function void note_byte(logic [7:0] c, bit last);
			logic [lcfp_pkg::PosW-1:0] p;
			logic [2:0]      f;
			bit              ok;
			frame_result_t   r;
			p = pos;
			if (p == 0 && c == lcfp_pkg::CharOpen) opened = 1;
			if (!closed) begin
				if (c == lcfp_pkg::CharClose) begin
					closed = 1;
				end else if (p < lcfp_pkg::PosSat) begin
					f = field_code(p);
					if (f != lcfp_pkg::FieldNone) acc[f] = {acc[f][3:0], hex_value(c)};
				end
			end
			if (pos < lcfp_pkg::PosSat) pos = pos + 1'b1;
			if (!last) return;
			ok = opened && c == lcfp_pkg::CharClose && p == lcfp_pkg::PosClose;
			if (ok) begin
				mode   = acc[lcfp_pkg::FieldMode];
				white  = acc[lcfp_pkg::FieldWhite];
				red    = acc[lcfp_pkg::FieldRed];
				green  = acc[lcfp_pkg::FieldGreen];
				blue   = acc[lcfp_pkg::FieldBlue];
				bright = acc[lcfp_pkg::FieldBright];
				speed  = (acc[lcfp_pkg::FieldSpeed] == 8'd0) ? 16'd1
					: {8'd0, acc[lcfp_pkg::FieldSpeed]};
			end else begin
				speed = speed + lcfp_pkg::ErrGrowth;
			end
			r.pad    = '0;
			r.ok     = ok;
			r.mode   = mode;
			r.white  = white;
			r.red    = red;
			r.green  = green;
			r.blue   = blue;
			r.bright = bright;
			r.speed  = speed;
			expected.push_back(r);
			clear_frame();
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch in %s: expected %0d actual %0d", name, want, got);
			end
		endfunction

		// one result transfer against the oldest queued settings word
		function void check_result(logic [71:0] word);
			frame_result_t got;
			frame_result_t want;
			got = word;
			if (expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("result with nothing expected: %h", word);
				return;
			end
			want = expected.pop_front();
			compare_field("frame_ok", want.ok, got.ok);
			compare_field("mode_out", want.mode, got.mode);
			compare_field("white_out", want.white, got.white);
			compare_field("red_out", want.red, got.red);
			compare_field("green_out", want.green, got.green);
			compare_field("blue_out", want.blue, got.blue);
			compare_field("brightness_out", want.bright, got.bright);
			compare_field("speed_out", want.speed, got.speed);
			compare_field("padding", want.pad, got.pad);
		endfunction

		function int pending();
			return expected.size();
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'd0;   // [7:0] rx_byte
	logic        s_tlast  = 1'b0;   // is_last
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;           // [0] frame_ok, [8:1] mode_out, [16:9] white_out,
	                                // [24:17] red_out, [32:25] green_out, [40:33] blue_out,
	                                // [48:41] brightness_out, [64:49] speed_out

	frame_scoreboard sb;
	logic [7:0]      frame_bytes [$];
	int              send_idle_pct = 0;
	int              recv_idle_pct = 0;
	int              hold_req = 0;
	int              byte_count = 0;
	bit              out_fire = 0;
	logic [71:0]     out_word;

	led_command_frame_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// offer one byte, with a random gap first; valid stays high into the next byte
	task automatic send_byte(input logic [7:0] b, input bit last);
		bit taken;
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do begin
				@(posedge clk);
			end while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		// handshake sampled mid-cycle, the transfer lands on the following edge
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		sb.note_byte(b, last);
		byte_count++;
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_bytes.size(); i++)
			send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
	endtask

	function automatic logic [7:0] hex_char(logic [3:0] n);
		if (n < 4'd10) return lcfp_pkg::CharDig0 + 8'(n);
		return (($urandom_range(1) != 0) ? lcfp_pkg::CharLoA : lcfp_pkg::CharUpA)
			+ 8'(n) - 8'd10;
	endfunction

	function automatic void push_hex(logic [7:0] v);
		frame_bytes.push_back(hex_char(v[7:4]));
		frame_bytes.push_back(hex_char(v[3:0]));
	endfunction

	// [MM:WWRRGGBB:BR:SP]
	function automatic void build_frame(logic [7:0] md, logic [7:0] wh, logic [7:0] rd,
	                                    logic [7:0] gr, logic [7:0] bl, logic [7:0] br,
	                                    logic [7:0] sp);
		frame_bytes.delete();
		frame_bytes.push_back(lcfp_pkg::CharOpen);
		push_hex(md);
		frame_bytes.push_back(CharSep);
		push_hex(wh);
		push_hex(rd);
		push_hex(gr);
		push_hex(bl);
		frame_bytes.push_back(CharSep);
		push_hex(br);
		frame_bytes.push_back(CharSep);
		push_hex(sp);
		frame_bytes.push_back(lcfp_pkg::CharClose);
	endfunction

	function automatic void random_frame();
		logic [7:0] sp;
		sp = ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(255));
		build_frame(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
		            8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
		            sp);
	endfunction

	// well-formed frames, some with one random byte overwritten, the rest broken frames and byte noise
	task automatic random_stimulus();
		int kind;
		int n;
		kind = $urandom_range(99);
		if (kind < 60) begin
			random_frame();
			if ($urandom_range(3) == 0) frame_bytes[$urandom_range(18)] = 8'($urandom_range(255));
		end else if (kind < 70) begin
			random_frame();
			if ($urandom_range(1) == 0) begin
				// overlong; the longer ones saturate the position count
				n = $urandom_range(1, 10);
				repeat (n) frame_bytes.insert($urandom_range(1, 17), hex_char(4'($urandom)));
			end else begin
				n = $urandom_range(17);
				while (frame_bytes.size() > n + 1) void'(frame_bytes.pop_back());
				if ($urandom_range(1) == 0) frame_bytes[n] = lcfp_pkg::CharClose;
			end
		end else if (kind < 80) begin
			// early close bracket cuts the fields short
			random_frame();
			frame_bytes[$urandom_range(1, 17)] = lcfp_pkg::CharClose;
		end else begin
			frame_bytes.delete();
			n = $urandom_range(1, 24);
			repeat (n) begin
				case ($urandom_range(7))
					0:       frame_bytes.push_back(lcfp_pkg::CharOpen);
					1:       frame_bytes.push_back(lcfp_pkg::CharClose);
					default: frame_bytes.push_back(8'($urandom_range(255)));
				endcase
			end
		end
		send_frame();
	endtask

	// receiver: random stalls, plus a long hold-off when asked
	initial begin
		int hold_left;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_fire) sb.check_result(out_word);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
			@(negedge clk);
			out_fire = m_tvalid && m_tready;
			out_word = m_tdata;
		end
	end

	initial begin
		int start;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 24;
		recv_idle_pct = 46;

		// plain accepted frame, all-zero fields with speed clamped up to one, then all-FF fields
		build_frame(8'h01, 8'h00, 8'hFF, 8'h7F, 8'h80, 8'hFF, 8'h10);
		send_frame();
		build_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_frame();
		build_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_frame();
		// non-hex bytes in the fields: small values, high values, other printable and control bytes
		build_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		frame_bytes[1]  = 8'h05;
		frame_bytes[2]  = 8'h80;
		frame_bytes[4]  = 8'h7F;
		frame_bytes[5]  = 8'hFF;
		frame_bytes[6]  = 8'd71;
		frame_bytes[7]  = 8'h0F;
		frame_bytes[8]  = 8'h10;
		frame_bytes[9]  = 8'h00;
		frame_bytes[16] = lcfp_pkg::CharOpen;
		send_frame();
		// early close bracket inside the blue field
		build_frame(8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'hDE);
		frame_bytes[10] = lcfp_pkg::CharClose;
		send_frame();
		// overlong frame
		build_frame(8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88);
		repeat (6) frame_bytes.insert(5, lcfp_pkg::CharDig0);
		send_frame();
		// too short
		frame_bytes = '{lcfp_pkg::CharOpen, lcfp_pkg::CharClose};
		send_frame();
		// wrong opening byte
		build_frame(8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04, 8'h03);
		frame_bytes[0] = 8'd88;
		send_frame();
		// missing closing bracket
		build_frame(8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04, 8'h03);
		frame_bytes[18] = lcfp_pkg::CharDig0;
		send_frame();
		// run of one-byte rejects, long enough for speed to wrap past 16 bits
		repeat (660) begin
			frame_bytes = '{8'($urandom_range(255))};
			send_frame();
		end

		start = byte_count;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 24;
					recv_idle_pct = 46;
				end
				1: begin
					send_idle_pct = 46;
					recv_idle_pct = 24;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			// long receiver hold-off so the parser backs up onto its input
			if (phase != 1) hold_req = 300;
			while (byte_count - start < (phase + 1) * 375) random_stimulus();
		end
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
